// ----- rtl/core/particle_pool_free_list_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_FREE_LIST_ASSERT_SVH
`define PARTICLE_POOL_FREE_LIST_ASSERT_SVH

// invariant checked at every edge
`define PPFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition now implies consequence at the next edge
`define PPFL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/core/ppfl_pkg.sv -----
// ----------------------------------------------------------------------------
// ppfl_pkg
// Types, sizes and the sine table builder for the particle pool.
// ----------------------------------------------------------------------------
package ppfl_pkg;

  localparam int POOL_DEPTH       = 4096;
  localparam int SLOT_W           = $clog2(POOL_DEPTH);
  localparam int CNT_W            = SLOT_W + 1;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SIN_ONE          = 16384;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef enum logic [1:0] {
    CMD_SPAWN,
    CMD_TICK,
    CMD_REVERSE,
    CMD_READ
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_FULL,
    STATUS_RANGE
  } status_t;

  typedef enum logic [0:0] {
    CFG_SCREEN_WIDTH,
    CFG_SCREEN_HEIGHT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN_MUL,
    ST_SPAWN_WR,
    ST_LIST_RD,
    ST_ENT_RD,
    ST_REV_WR,
    ST_MOVE_MUL,
    ST_MOVE_WR,
    ST_PUSH,
    ST_READ_LIST,
    ST_READ_ENT,
    ST_READ_CAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] speed;
    logic [9:0]         angle;
    logic               owner;
    logic [15:0]        damage;
    logic [11:0]        radius;
    logic [15:0]        time_step;
    logic [SLOT_W-1:0]  index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [CNT_W-1:0]   active_count;
    logic [CNT_W-1:0]   retired_count;
    logic signed [15:0] out_pos_x;
    logic signed [15:0] out_pos_y;
    logic               out_owner;
    logic [15:0]        out_damage;
    logic [11:0]        out_radius;
  } out_item_t;

  // one pool entry as stored in the entry memory
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               owner;
    logic [15:0]        damage;
    logic [11:0]        radius;
  } entry_t;

  // quarter-wave sine entry in Q1.14 from a Q30 Taylor series
  function automatic logic [14:0] sine_entry(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      s;
    longint      q;
    if (idx >= SINE_TABLE_DEPTH) begin
      return 15'(SIN_ONE);
    end
    x  = (PI_Q30 * 64'(idx)) / (2 * SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd156;
    s  = s + longint'(t);
    if (s < 0) begin
      s = 0;
    end
    q = (s + 32768) >>> 16;
    if (q > SIN_ONE) begin
      q = SIN_ONE;
    end
    return 15'(q);
  endfunction

endpackage

// ----- rtl/core/ppfl_ram.sv -----
// ----------------------------------------------------------------------------
// ppfl_ram
// Synchronous RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ppfl_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/ppfl_velocity.sv -----
// ----------------------------------------------------------------------------
// ppfl_velocity
// Spawn velocity: sine table lookup and 3*speed*(cos, sin) in Q12.4.
// ----------------------------------------------------------------------------
module ppfl_velocity (
  input  logic               clk,
  input  logic signed [15:0] speed,
  input  logic [9:0]         angle,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y
);

  localparam int PROD_W = ppfl_pkg::SINE_IDX_W + 9;

  logic [14:0]        sine_rom [ppfl_pkg::SINE_TABLE_DEPTH + 1];
  logic [9:0]         lane_ang [2];
  logic signed [15:0] trig     [2];
  logic signed [17:0] speed3;
  logic signed [34:0] prod_r   [2];
  logic signed [34:0] rnd      [2];
  logic signed [15:0] vel      [2];

  // constant quarter-wave table
  for (genvar g = 0; g <= ppfl_pkg::SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [14:0] VAL = ppfl_pkg::sine_entry(g);
    assign sine_rom[g] = VAL;
  end

  // lane 0 is cosine (quarter turn ahead), lane 1 is sine
  assign lane_ang[0] = angle + 10'd256;
  assign lane_ang[1] = angle;
  assign speed3      = 18'(speed) + 18'(speed) + 18'(speed);

  // quadrant fold and lookup
  always_comb begin
    logic [8:0]        off;
    logic [PROD_W-1:0] scaled;
    logic [14:0]       mag;
    for (int l = 0; l < 2; l++) begin
      off = {1'b0, lane_ang[l][7:0]};
      if (lane_ang[l][8]) begin
        off = 9'd256 - off;
      end
      scaled = PROD_W'(off) * PROD_W'(ppfl_pkg::SINE_TABLE_DEPTH);
      mag    = sine_rom[scaled[ppfl_pkg::SINE_IDX_W+7:8]];
      trig[l] = lane_ang[l][9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  // product register
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      prod_r[l] <= 35'(speed3) * 35'(trig[l]);
    end
  end

  // round to Q12.4 and saturate
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rnd[l] = (prod_r[l] + 35'sd8192) >>> 14;
      if (rnd[l] > 35'sd32767) begin
        vel[l] = 16'sh7fff;
      end else if (rnd[l] < -35'sd32768) begin
        vel[l] = 16'sh8000;
      end else begin
        vel[l] = rnd[l][15:0];
      end
    end
  end

  assign vel_x = vel[0];
  assign vel_y = vel[1];

endmodule

// ----- rtl/core/ppfl_move_lane.sv -----
// ----------------------------------------------------------------------------
// ppfl_move_lane
// One axis of the tick update: pos + round(vel*dt), saturated.
// ----------------------------------------------------------------------------
module ppfl_move_lane (
  input  logic               clk,
  input  logic signed [15:0] pos,
  input  logic signed [15:0] vel,
  input  logic [15:0]        time_step,
  output logic signed [15:0] pos_new
);

  logic signed [15:0] pos_r;
  logic signed [33:0] prod_r;
  logic signed [33:0] delta;
  logic signed [18:0] sum;

  // operand and product registers
  always_ff @(posedge clk) begin
    pos_r  <= pos;
    prod_r <= 34'(vel) * $signed({18'd0, time_step});
  end

  assign delta = (prod_r + 34'sd32768) >>> 16;
  assign sum   = 19'(pos_r) + $signed(delta[18:0]);

  // saturate to 16 bits signed
  always_comb begin
    if (sum > 19'sd32767) begin
      pos_new = 16'sh7fff;
    end else if (sum < -19'sd32768) begin
      pos_new = 16'sh8000;
    end else begin
      pos_new = sum[15:0];
    end
  end

endmodule

// ----- rtl/core/particle_pool_free_list.sv -----
// ----------------------------------------------------------------------------
// particle_pool_free_list
// Object pool with a free stack and a dense active list in one slot memory.
// ----------------------------------------------------------------------------
// One item is handled at a time; each command is a sequence of registered
// reads and write-backs on two memories: the slot memory (active list
// growing from address 0, free stack growing down from the top, so the two
// never overlap) and the entry memory. Before the next acceptance, a
// finished result waits in the done state while the previous result is
// still held in the output register by out_stall. The per-entry walk
// through the memories sets the tick and reverse times. No clearing pass
// follows reset: never-used free slots are supplied from a high-water
// mark. A finished result waits in the output register while the next
// item is accepted.
module particle_pool_free_list (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ppfl_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ppfl_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  ppfl_pkg::cfg_reg_t    cfg_index,
  input  logic [11:0]           cfg_data
);

  localparam int SLOT_W = ppfl_pkg::SLOT_W;
  localparam int CNT_W  = ppfl_pkg::CNT_W;
  localparam int ENT_W  = $bits(ppfl_pkg::entry_t);

  ppfl_pkg::state_t    state_r, state_nxt;
  ppfl_pkg::in_item_t  req_r;
  ppfl_pkg::status_t   res_status_r, res_status_nxt;
  ppfl_pkg::entry_t    ent_r, ent_nxt;
  ppfl_pkg::entry_t    en_rd, en_wr;
  ppfl_pkg::out_item_t out_data_r, out_data_nxt;

  logic [11:0]        width_r, height_r;
  logic [CNT_W-1:0]   active_r, active_nxt;
  logic [CNT_W-1:0]   hw_r, hw_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   retired_r, retired_nxt;
  logic [SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [SLOT_W-1:0]  s_r, s_nxt;
  logic [SLOT_W-1:0]  last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic               in_accept;

  logic               sl_we;
  logic [SLOT_W-1:0]  sl_waddr, sl_wdata, sl_raddr_a, sl_raddr_b;
  logic [SLOT_W-1:0]  sl_rdata_a, sl_rdata_b;
  logic               en_we;
  logic [SLOT_W-1:0]  en_waddr, en_raddr;
  logic [ENT_W-1:0]   en_rdata;

  logic signed [15:0] spawn_vx, spawn_vy;
  logic signed [15:0] new_x, new_y;
  logic [SLOT_W-1:0]  last_addr, spawn_slot;
  logic               fresh;
  logic               cull;
  logic signed [18:0] x_ext, y_ext, rad_ext, x_hi, y_hi;

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ppfl_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign en_rd     = ppfl_pkg::entry_t'(en_rdata);

  // slot memory: active list below active_r, free stack above
  ppfl_ram #(.WIDTH(SLOT_W), .DEPTH(ppfl_pkg::POOL_DEPTH)) u_slot_ram (
    .clk     (clk),
    .we      (sl_we),
    .waddr   (sl_waddr),
    .wdata   (sl_wdata),
    .raddr_a (sl_raddr_a),
    .rdata_a (sl_rdata_a),
    .raddr_b (sl_raddr_b),
    .rdata_b (sl_rdata_b)
  );

  // entry memory, indexed by slot
  ppfl_ram #(.WIDTH(ENT_W), .DEPTH(ppfl_pkg::POOL_DEPTH)) u_entry_ram (
    .clk     (clk),
    .we      (en_we),
    .waddr   (en_waddr),
    .wdata   (en_wr),
    .raddr_a (en_raddr),
    .rdata_a (en_rdata),
    .raddr_b (en_raddr),
    .rdata_b ()
  );

  ppfl_velocity u_velocity (
    .clk   (clk),
    .speed (req_r.speed),
    .angle (req_r.angle),
    .vel_x (spawn_vx),
    .vel_y (spawn_vy)
  );

  ppfl_move_lane u_move_x (
    .clk       (clk),
    .pos       (en_rd.pos_x),
    .vel       (en_rd.vel_x),
    .time_step (req_r.time_step),
    .pos_new   (new_x)
  );

  ppfl_move_lane u_move_y (
    .clk       (clk),
    .pos       (en_rd.pos_y),
    .vel       (en_rd.vel_y),
    .time_step (req_r.time_step),
    .pos_new   (new_y)
  );

  // cull test against the screen widened by the radius
  assign x_ext   = 19'(new_x);
  assign y_ext   = 19'(new_y);
  assign rad_ext = $signed({7'd0, ent_r.radius});
  assign x_hi    = $signed({3'd0, width_r, 4'd0}) + rad_ext;
  assign y_hi    = $signed({3'd0, height_r, 4'd0}) + rad_ext;
  assign cull    = (x_ext < -rad_ext) || (x_ext > x_hi) ||
                   (y_ext < -rad_ext) || (y_ext > y_hi);

  // a free-stack address at or above the high-water mark was never written
  assign last_addr  = SLOT_W'(active_r - CNT_W'(1));
  assign fresh      = (active_r >= hw_r);
  assign spawn_slot = fresh ? SLOT_W'(active_r) : sl_rdata_a;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    hw_nxt         = hw_r;
    i_nxt          = i_r;
    retired_nxt    = retired_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_ok_nxt     = res_ok_r;
    s_nxt          = s_r;
    last_nxt       = last_r;
    ent_nxt        = ent_r;
    out_load       = 1'b0;
    sl_we          = 1'b0;
    sl_waddr       = SLOT_W'(i_r);
    sl_wdata       = s_r;
    sl_raddr_a     = SLOT_W'(i_r);
    sl_raddr_b     = last_addr;
    en_we          = 1'b0;
    en_waddr       = s_r;
    en_raddr       = sl_rdata_a;
    en_wr          = ent_r;
    unique case (state_r)
      ppfl_pkg::ST_IDLE: begin
        if (in_accept) begin
          retired_nxt    = '0;
          i_nxt          = '0;
          res_status_nxt = ppfl_pkg::STATUS_OK;
          res_slot_nxt   = '0;
          res_ok_nxt     = 1'b0;
          unique case (in_data.cmd) inside
            ppfl_pkg::CMD_SPAWN: begin
              if (active_r == CNT_W'(ppfl_pkg::POOL_DEPTH)) begin
                res_status_nxt = ppfl_pkg::STATUS_FULL;
                state_nxt      = ppfl_pkg::ST_DONE;
              end else begin
                state_nxt = ppfl_pkg::ST_SPAWN_MUL;
              end
            end
            ppfl_pkg::CMD_TICK, ppfl_pkg::CMD_REVERSE: begin
              state_nxt = (active_r == '0) ? ppfl_pkg::ST_DONE : ppfl_pkg::ST_LIST_RD;
            end
            ppfl_pkg::CMD_READ: begin
              if (CNT_W'(in_data.index) >= active_r) begin
                res_status_nxt = ppfl_pkg::STATUS_RANGE;
                state_nxt      = ppfl_pkg::ST_DONE;
              end else begin
                state_nxt = ppfl_pkg::ST_READ_LIST;
              end
            end
            default: state_nxt = ppfl_pkg::ST_IDLE;
          endcase
        end
      end
      // free top sits at address active_r
      ppfl_pkg::ST_SPAWN_MUL: begin
        sl_raddr_a = SLOT_W'(active_r);
        state_nxt  = ppfl_pkg::ST_SPAWN_WR;
      end
      ppfl_pkg::ST_SPAWN_WR: begin
        en_we        = 1'b1;
        en_waddr     = spawn_slot;
        en_wr.pos_x  = req_r.pos_x;
        en_wr.pos_y  = req_r.pos_y;
        en_wr.vel_x  = spawn_vx;
        en_wr.vel_y  = spawn_vy;
        en_wr.owner  = req_r.owner;
        en_wr.damage = req_r.damage;
        en_wr.radius = req_r.radius;
        sl_we        = 1'b1;
        sl_waddr     = SLOT_W'(active_r);
        sl_wdata     = spawn_slot;
        active_nxt   = active_r + CNT_W'(1);
        if (fresh) begin
          hw_nxt = active_r + CNT_W'(1);
        end
        res_slot_nxt = spawn_slot;
        state_nxt    = ppfl_pkg::ST_DONE;
      end
      // walk: fetch list[i] and list[last]
      ppfl_pkg::ST_LIST_RD: begin
        state_nxt = ppfl_pkg::ST_ENT_RD;
      end
      ppfl_pkg::ST_ENT_RD: begin
        s_nxt     = sl_rdata_a;
        last_nxt  = sl_rdata_b;
        en_raddr  = sl_rdata_a;
        state_nxt = (req_r.cmd == ppfl_pkg::CMD_TICK) ? ppfl_pkg::ST_MOVE_MUL
                                                      : ppfl_pkg::ST_REV_WR;
      end
      ppfl_pkg::ST_REV_WR: begin
        en_we       = 1'b1;
        en_wr       = en_rd;
        en_wr.vel_x = neg_sat(en_rd.vel_x);
        en_wr.vel_y = neg_sat(en_rd.vel_y);
        i_nxt       = i_r + CNT_W'(1);
        state_nxt   = (i_r + CNT_W'(1) == active_r) ? ppfl_pkg::ST_DONE
                                                    : ppfl_pkg::ST_LIST_RD;
      end
      ppfl_pkg::ST_MOVE_MUL: begin
        ent_nxt   = en_rd;
        state_nxt = ppfl_pkg::ST_MOVE_WR;
      end
      ppfl_pkg::ST_MOVE_WR: begin
        en_we       = 1'b1;
        en_wr.pos_x = new_x;
        en_wr.pos_y = new_y;
        if (cull) begin
          // last active moves into the hole
          sl_we       = 1'b1;
          sl_waddr    = SLOT_W'(i_r);
          sl_wdata    = last_r;
          retired_nxt = retired_r + CNT_W'(1);
          state_nxt   = ppfl_pkg::ST_PUSH;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = (i_r + CNT_W'(1) == active_r) ? ppfl_pkg::ST_DONE
                                                    : ppfl_pkg::ST_LIST_RD;
        end
      end
      // retired slot goes on top of the free stack
      ppfl_pkg::ST_PUSH: begin
        sl_we      = 1'b1;
        sl_waddr   = last_addr;
        sl_wdata   = s_r;
        active_nxt = active_r - CNT_W'(1);
        state_nxt  = (i_r == active_r - CNT_W'(1)) ? ppfl_pkg::ST_DONE
                                                   : ppfl_pkg::ST_LIST_RD;
      end
      ppfl_pkg::ST_READ_LIST: begin
        sl_raddr_a = req_r.index;
        state_nxt  = ppfl_pkg::ST_READ_ENT;
      end
      ppfl_pkg::ST_READ_ENT: begin
        s_nxt     = sl_rdata_a;
        en_raddr  = sl_rdata_a;
        state_nxt = ppfl_pkg::ST_READ_CAP;
      end
      ppfl_pkg::ST_READ_CAP: begin
        ent_nxt      = en_rd;
        res_ok_nxt   = 1'b1;
        res_slot_nxt = s_r;
        state_nxt    = ppfl_pkg::ST_DONE;
      end
      ppfl_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ppfl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppfl_pkg::ST_IDLE;
    endcase
  end

  // result assembly
  always_comb begin
    out_data_nxt.status        = res_status_r;
    out_data_nxt.slot          = res_slot_r;
    out_data_nxt.active_count  = active_r;
    out_data_nxt.retired_count = retired_r;
    out_data_nxt.out_pos_x     = res_ok_r ? ent_r.pos_x  : '0;
    out_data_nxt.out_pos_y     = res_ok_r ? ent_r.pos_y  : '0;
    out_data_nxt.out_owner     = res_ok_r ? ent_r.owner  : 1'b0;
    out_data_nxt.out_damage    = res_ok_r ? ent_r.damage : '0;
    out_data_nxt.out_radius    = res_ok_r ? ent_r.radius : '0;
    out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppfl_pkg::ST_IDLE;
      active_r     <= '0;
      hw_r         <= '0;
      i_r          <= '0;
      retired_r    <= '0;
      res_status_r <= ppfl_pkg::STATUS_OK;
      res_slot_r   <= '0;
      res_ok_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      width_r      <= 12'd1600;
      height_r     <= 12'd900;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      hw_r         <= hw_nxt;
      i_r          <= i_nxt;
      retired_r    <= retired_nxt;
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      res_ok_r     <= res_ok_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ppfl_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_data;
          ppfl_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
    s_r    <= s_nxt;
    last_r <= last_nxt;
    ent_r  <= ent_nxt;
  end

`include "particle_pool_free_list_assert.svh"

  `PPFL_ASSERT(a_active_bound, active_r <= CNT_W'(ppfl_pkg::POOL_DEPTH), "active count above pool depth")
  `PPFL_ASSERT(a_high_water, hw_r >= active_r, "high-water mark below active count")
  `PPFL_ASSERT_NEXT(a_push_dec, state_r == ppfl_pkg::ST_PUSH, active_r == $past(active_r) - 1'b1, "retire did not shrink active list")
  `PPFL_ASSERT_NEXT(a_spawn_inc, state_r == ppfl_pkg::ST_SPAWN_WR, active_r == $past(active_r) + 1'b1, "spawn did not grow active list")

endmodule
